### design/knps_pkg.sv
package knps_pkg;

	// table and list sizes
	localparam int TABLE_SLOTS    = 64;
	localparam int MAX_NEIGHBOURS = 8;

	// derived widths
	localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int SCAN_W = $clog2(TABLE_SLOTS + 1);
	localparam int LIST_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);

	// field and arithmetic widths
	localparam int COORD_W    = 24;
	localparam int SLOT_W     = 6;
	localparam int CFG_W      = 4;
	localparam int CFG_RESET  = 4;
	localparam int DIFF_W     = 24;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SQ_W       = PROD_W + 2;
	localparam int ROOT_W     = 25;
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int IN_W       = 80;
	localparam int OUT_W      = 40;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIFF,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_ACC,
		ST_INSERT,
		ST_RANK,
		ST_ROOT,
		ST_OUT
	} state_t;

	// input item, lowest field last
	typedef struct packed {
		logic                      pad;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_x;
		logic                      present;
		logic [SLOT_W-1:0]         slot;
	} in_item_t;

	// result item, lowest field last
	typedef struct packed {
		logic              pad;
		logic [3:0]        found_count;
		logic [ROOT_W-1:0] distance;
		logic              found;
		logic [SLOT_W-1:0] neighbour_slot;
		logic [2:0]        rank;
	} out_item_t;

endpackage

### design/knps_ram.sv
module knps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/k_nearest_point_select.sv
// a load gives no result
// a query scans every table slot, one shared multiplier squaring the three axis differences
// of each present slot in turn, then runs the 25-step root unit for each filled rank;
// an empty rank skips the root, and each result waits on m_tready
// one item at a time: s_tready is high only between items
// arst_n clears the control state, the present bits and neighbour_count (to 4)
module k_nearest_point_select (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// tuser: operation
	input  logic                       s_tuser,
	// tdata: slot, present, pos_x, pos_y, pos_z, zero pad
	input  logic [knps_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// tdata: rank, neighbour_slot, found, distance, found_count, zero pad
	output logic [knps_pkg::OUT_W-1:0] m_tdata,
	output logic                       m_tlast,
	input  logic                       cfg_wen,
	input  logic [knps_pkg::CFG_W-1:0] cfg_wdata
);

	knps_pkg::state_t state_q, state_d;
	knps_pkg::in_item_t in_item;

	logic [knps_pkg::CFG_W-1:0]       ncount_q;
	logic [knps_pkg::TABLE_SLOTS-1:0] present_q;
	logic [knps_pkg::COORD_W-1:0]     qx_q, qy_q, qz_q;
	logic [knps_pkg::CNT_W-1:0]       k_q, filled_q, rank_q;
	logic [knps_pkg::SCAN_W-1:0]      scan_q;
	logic [knps_pkg::ADDR_W-1:0]      cur_slot_q;
	logic [knps_pkg::DIFF_W-1:0]      dx_q, dy_q, dz_q;
	logic [knps_pkg::PROD_W-1:0]      prod_q;
	logic [knps_pkg::SQ_W-1:0]        acc_q;
	logic [knps_pkg::SQ_W-1:0]        best_sq_q   [knps_pkg::MAX_NEIGHBOURS];
	logic [knps_pkg::SLOT_W-1:0]      best_slot_q [knps_pkg::MAX_NEIGHBOURS];
	logic [knps_pkg::SQ_W-1:0]        next_sq     [knps_pkg::MAX_NEIGHBOURS];
	logic [knps_pkg::SLOT_W-1:0]      next_slot   [knps_pkg::MAX_NEIGHBOURS];
	logic [knps_pkg::MAX_NEIGHBOURS-1:0] cand;
	logic [knps_pkg::SQ_W-1:0]        root_v_q, root_res_q, root_bit_q, trial;
	logic [knps_pkg::SQ_W-1:0]        root_v_d, root_res_d;
	logic [knps_pkg::STEP_W-1:0]      step_q;
	knps_pkg::out_item_t              out_q;
	logic                             last_q;

	logic                          accept, scan_done, slot_ok, is_present, rank_last;
	logic [knps_pkg::CNT_W-1:0]    k_eff;
	logic [knps_pkg::DIFF_W-1:0]   mul_in;
	logic [3*knps_pkg::COORD_W-1:0] rd_data;
	logic [knps_pkg::LIST_W-1:0]   rank_idx;

	// magnitude of the difference of two signed coordinates
	function automatic logic [knps_pkg::DIFF_W-1:0] abs_diff(
		input logic [knps_pkg::COORD_W-1:0] a,
		input logic [knps_pkg::COORD_W-1:0] b
	);
		logic [knps_pkg::COORD_W:0] dd;
		logic [knps_pkg::COORD_W:0] mag;
		dd  = {a[knps_pkg::COORD_W-1], a} - {b[knps_pkg::COORD_W-1], b};
		mag = dd[knps_pkg::COORD_W] ? (~dd + 1'b1) : dd;
		return mag[knps_pkg::DIFF_W-1:0];
	endfunction

	assign in_item    = knps_pkg::in_item_t'(s_tdata);
	assign accept     = s_tvalid && s_tready;
	assign slot_ok    = int'(in_item.slot) < knps_pkg::TABLE_SLOTS;
	assign scan_done  = scan_q == knps_pkg::SCAN_W'(knps_pkg::TABLE_SLOTS);
	assign is_present = present_q[scan_q[knps_pkg::ADDR_W-1:0]];
	assign rank_idx   = rank_q[knps_pkg::LIST_W-1:0];
	assign rank_last  = rank_q == k_q - 1'b1;

	// effective rank count: zero acts as one, clamp at the list size
	always_comb begin
		if (ncount_q == '0) begin
			k_eff = knps_pkg::CNT_W'(1);
		end else if (int'(ncount_q) > knps_pkg::MAX_NEIGHBOURS) begin
			k_eff = knps_pkg::CNT_W'(knps_pkg::MAX_NEIGHBOURS);
		end else begin
			k_eff = knps_pkg::CNT_W'(ncount_q);
		end
	end

	// point store: x, y, z side by side
	knps_ram #(
		.WIDTH(3 * knps_pkg::COORD_W),
		.DEPTH(knps_pkg::TABLE_SLOTS)
	) u_store (
		.clk    (clk),
		.wr_en  (accept && in_item.present && slot_ok &&
		         (knps_pkg::op_t'(s_tuser) == knps_pkg::OP_LOAD)),
		.wr_addr(knps_pkg::ADDR_W'(in_item.slot)),
		.wr_data({in_item.pos_z, in_item.pos_y, in_item.pos_x}),
		.rd_en  ((state_q == knps_pkg::ST_SCAN) && !scan_done && is_present),
		.rd_addr(scan_q[knps_pkg::ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= knps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			knps_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (knps_pkg::op_t'(s_tuser) == knps_pkg::OP_QUERY)) begin
					state_d = knps_pkg::ST_SCAN;
				end
			end
			knps_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = knps_pkg::ST_RANK;
				end else if (is_present) begin
					state_d = knps_pkg::ST_DIFF;
				end
			end
			knps_pkg::ST_DIFF:   state_d = knps_pkg::ST_MUL_X;
			knps_pkg::ST_MUL_X:  state_d = knps_pkg::ST_MUL_Y;
			knps_pkg::ST_MUL_Y:  state_d = knps_pkg::ST_MUL_Z;
			knps_pkg::ST_MUL_Z:  state_d = knps_pkg::ST_ACC;
			knps_pkg::ST_ACC:    state_d = knps_pkg::ST_INSERT;
			knps_pkg::ST_INSERT: state_d = knps_pkg::ST_SCAN;
			knps_pkg::ST_RANK: begin
				state_d = (rank_q < filled_q) ? knps_pkg::ST_ROOT : knps_pkg::ST_OUT;
			end
			knps_pkg::ST_ROOT: begin
				if (step_q == knps_pkg::STEP_W'(knps_pkg::ROOT_STEPS - 1)) begin
					state_d = knps_pkg::ST_OUT;
				end
			end
			knps_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = last_q ? knps_pkg::ST_IDLE : knps_pkg::ST_RANK;
				end
			end
			default: state_d = knps_pkg::ST_IDLE;
		endcase
	end

	// insertion point: first rank that is free or beaten by the new square
	always_comb begin
		for (int i = 0; i < knps_pkg::MAX_NEIGHBOURS; i++) begin
			cand[i] = (knps_pkg::CNT_W'(i) < k_q) &&
			          ((knps_pkg::CNT_W'(i) >= filled_q) || (acc_q < best_sq_q[i]));
		end
	end

	// shifted list with the new entry in place
	always_comb begin
		next_sq   = best_sq_q;
		next_slot = best_slot_q;
		if (cand[0]) begin
			next_sq[0]   = acc_q;
			next_slot[0] = knps_pkg::SLOT_W'(cur_slot_q);
		end
		for (int i = 1; i < knps_pkg::MAX_NEIGHBOURS; i++) begin
			if (cand[i]) begin
				if (!cand[i-1]) begin
					next_sq[i]   = acc_q;
					next_slot[i] = knps_pkg::SLOT_W'(cur_slot_q);
				end else begin
					next_sq[i]   = best_sq_q[i-1];
					next_slot[i] = best_slot_q[i-1];
				end
			end
		end
	end

	// shared multiplier operand
	always_comb begin
		case (state_q)
			knps_pkg::ST_MUL_Y: mul_in = dy_q;
			knps_pkg::ST_MUL_Z: mul_in = dz_q;
			default:            mul_in = dx_q;
		endcase
	end

	// one step of the bitwise square root
	always_comb begin
		trial = root_res_q + root_bit_q;
		if (root_v_q >= trial) begin
			root_v_d   = root_v_q - trial;
			root_res_d = (root_res_q >> 1) + root_bit_q;
		end else begin
			root_v_d   = root_v_q;
			root_res_d = root_res_q >> 1;
		end
	end

	// configuration register and present bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q  <= knps_pkg::CFG_W'(knps_pkg::CFG_RESET);
			present_q <= '0;
		end else begin
			if (cfg_wen) begin
				ncount_q <= cfg_wdata;
			end
			if (accept && slot_ok && (knps_pkg::op_t'(s_tuser) == knps_pkg::OP_LOAD)) begin
				present_q[knps_pkg::ADDR_W'(in_item.slot)] <= in_item.present;
			end
		end
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			filled_q <= '0;
			rank_q   <= '0;
			k_q      <= '0;
			step_q   <= '0;
		end else begin
			case (state_q)
				knps_pkg::ST_IDLE: begin
					scan_q   <= '0;
					filled_q <= '0;
					rank_q   <= '0;
					k_q      <= k_eff;
				end
				knps_pkg::ST_SCAN: begin
					if (!scan_done) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				knps_pkg::ST_INSERT: begin
					if ((|cand) && (filled_q < k_q)) begin
						filled_q <= filled_q + 1'b1;
					end
				end
				knps_pkg::ST_RANK: step_q <= '0;
				knps_pkg::ST_ROOT: step_q <= step_q + 1'b1;
				knps_pkg::ST_OUT: begin
					if (m_tready) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			knps_pkg::ST_IDLE: begin
				qx_q <= in_item.pos_x;
				qy_q <= in_item.pos_y;
				qz_q <= in_item.pos_z;
			end
			knps_pkg::ST_SCAN: cur_slot_q <= scan_q[knps_pkg::ADDR_W-1:0];
			knps_pkg::ST_DIFF: begin
				dx_q <= abs_diff(rd_data[knps_pkg::COORD_W-1:0], qx_q);
				dy_q <= abs_diff(rd_data[2*knps_pkg::COORD_W-1:knps_pkg::COORD_W], qy_q);
				dz_q <= abs_diff(rd_data[3*knps_pkg::COORD_W-1:2*knps_pkg::COORD_W], qz_q);
			end
			knps_pkg::ST_MUL_X: prod_q <= mul_in * mul_in;
			knps_pkg::ST_MUL_Y: begin
				prod_q <= mul_in * mul_in;
				acc_q  <= knps_pkg::SQ_W'(prod_q);
			end
			knps_pkg::ST_MUL_Z: begin
				prod_q <= mul_in * mul_in;
				acc_q  <= acc_q + knps_pkg::SQ_W'(prod_q);
			end
			knps_pkg::ST_ACC: acc_q <= acc_q + knps_pkg::SQ_W'(prod_q);
			knps_pkg::ST_INSERT: begin
				best_sq_q   <= next_sq;
				best_slot_q <= next_slot;
			end
			knps_pkg::ST_RANK: begin
				root_v_q   <= best_sq_q[rank_idx];
				root_res_q <= '0;
				root_bit_q <= knps_pkg::SQ_W'(1) << (2 * (knps_pkg::ROOT_STEPS - 1));
				last_q     <= rank_last;
				out_q.pad         <= 1'b0;
				out_q.found_count <= 4'(filled_q);
				out_q.rank        <= 3'(rank_q);
				// empty rank reports zeros
				out_q.found          <= rank_q < filled_q;
				out_q.neighbour_slot <= (rank_q < filled_q) ? best_slot_q[rank_idx] : '0;
				out_q.distance       <= '0;
			end
			knps_pkg::ST_ROOT: begin
				root_v_q   <= root_v_d;
				root_res_q <= root_res_d;
				root_bit_q <= root_bit_q >> 2;
				out_q.distance <= knps_pkg::ROOT_W'(root_res_d);
			end
			default: ;
		endcase
	end

	assign m_tdata = out_q;
	assign m_tlast = last_q;

endmodule

### design/knps_checker.sv
module knps_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [knps_pkg::OUT_W-1:0] m_tdata,
	input logic                       m_tlast
);

	knps_pkg::out_item_t mo;
	assign mo = knps_pkg::out_item_t'(m_tdata);

	// no new item is taken while a result is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// ranks below the found count are filled, the rest empty
	a_found_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mo.found == ({1'b0, mo.rank} < mo.found_count)))
		else $error("found flag does not match rank and found count");

	// after the final result the block is free again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("block not free after final result");

	// more results follow a result that is not the last
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("query ended before its final result");

endmodule

bind k_nearest_point_select knps_checker u_knps_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// worst case per query: full table scan, eight roots and long result stalls
	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam int          SETTLE_CYCLES = 700;

	localparam logic signed [knps_pkg::COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [knps_pkg::COORD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [knps_pkg::COORD_W-1:0] UNIT      = 24'sd256;

	typedef struct {
		bit [2:0]                  rank;
		bit [knps_pkg::SLOT_W-1:0] neighbour_slot;
		bit                        found;
		bit [knps_pkg::ROOT_W-1:0] distance;
		bit [3:0]                  found_count;
		bit                        last;
	} neighbour_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic                       s_tuser;
	logic [knps_pkg::IN_W-1:0]  s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [knps_pkg::OUT_W-1:0] m_tdata;
	logic                       m_tlast;
	logic                       cfg_wen;
	logic [knps_pkg::CFG_W-1:0] cfg_wdata;

	// predictor state
	logic signed [knps_pkg::COORD_W-1:0] table_x [knps_pkg::TABLE_SLOTS];
	logic signed [knps_pkg::COORD_W-1:0] table_y [knps_pkg::TABLE_SLOTS];
	logic signed [knps_pkg::COORD_W-1:0] table_z [knps_pkg::TABLE_SLOTS];
	bit                                  table_present [knps_pkg::TABLE_SLOTS];
	bit [knps_pkg::CFG_W-1:0]            neighbour_setting;
	neighbour_result_t                   pending_neighbours [$];

	int          error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	k_nearest_point_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// random back-pressure on results
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// floor square root, built up one result bit at a time from the top
	function automatic bit [knps_pkg::ROOT_W-1:0] floor_root(input longint sq);
		bit [knps_pkg::ROOT_W-1:0] root;
		longint                    trial;
		root = '0;
		for (int b = knps_pkg::ROOT_W - 1; b >= 0; b--) begin
			root[b] = 1'b1;
			trial   = longint'(root);
			if (trial * trial > sq)
				root[b] = 1'b0;
		end
		return root;
	endfunction

	// nearest-point search over the present slots, queues one result per rank
	task automatic predict_nearest(input logic signed [knps_pkg::COORD_W-1:0] qx, qy, qz);
		int                ranks;
		int                filled;
		int                pos;
		longint            dx, dy, dz, sq;
		longint            best_sq [knps_pkg::MAX_NEIGHBOURS];
		int                best_slot [knps_pkg::MAX_NEIGHBOURS];
		neighbour_result_t res;
		if (neighbour_setting == 0)
			ranks = 1;
		else if (neighbour_setting > knps_pkg::MAX_NEIGHBOURS)
			ranks = knps_pkg::MAX_NEIGHBOURS;
		else
			ranks = int'(neighbour_setting);
		filled = 0;
		for (int s = 0; s < knps_pkg::TABLE_SLOTS; s++) begin
			if (!table_present[s])
				continue;
			dx = longint'(table_x[s]) - longint'(qx);
			dy = longint'(table_y[s]) - longint'(qy);
			dz = longint'(table_z[s]) - longint'(qz);
			sq = dx * dx + dy * dy + dz * dz;
			// strictly closer only, so the earlier slot keeps a tied rank
			pos = 0;
			while (pos < filled && sq >= best_sq[pos])
				pos++;
			if (pos < ranks) begin
				for (int j = ranks - 1; j > pos; j--) begin
					best_sq[j]   = best_sq[j - 1];
					best_slot[j] = best_slot[j - 1];
				end
				best_sq[pos]   = sq;
				best_slot[pos] = s;
				if (filled < ranks)
					filled++;
			end
		end
		for (int i = 0; i < ranks; i++) begin
			res.rank           = 3'(i);
			res.found          = (i < filled);
			res.neighbour_slot = res.found ? knps_pkg::SLOT_W'(best_slot[i]) : '0;
			res.distance       = res.found ? floor_root(best_sq[i]) : '0;
			res.found_count    = 4'(filled);
			res.last           = (i == ranks - 1);
			pending_neighbours = {pending_neighbours, res};
		end
	endtask

	// drive one item after a random gap and wait until it is taken
	task automatic issue_item(input knps_pkg::op_t op, input logic [knps_pkg::SLOT_W-1:0] slot,
		input logic present, input logic signed [knps_pkg::COORD_W-1:0] x, y, z);
		knps_pkg::in_item_t item;
		item.pad     = 1'b0;
		item.slot    = slot;
		item.present = present;
		item.pos_x   = x;
		item.pos_y   = y;
		item.pos_z   = z;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= item;
		do
			@(posedge clk);
		while (!s_tready);
		if (op == knps_pkg::OP_QUERY) begin
			predict_nearest(x, y, z);
		end else begin
			// clearing keeps the stored coordinates
			table_present[slot] = present;
			if (present) begin
				table_x[slot] = x;
				table_y[slot] = y;
				table_z[slot] = z;
			end
		end
		@(negedge clk);
	endtask

	// stop sending and let every awaited result come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_neighbours.size() != 0)
			@(negedge clk);
		// a load may still be finishing
		repeat (4) @(negedge clk);
	endtask

	task automatic set_neighbour_count(input bit [knps_pkg::CFG_W-1:0] value);
		wait_for_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		neighbour_setting = value;
	endtask

	function automatic logic signed [knps_pkg::COORD_W-1:0] pick_coord(
		input logic signed [knps_pkg::COORD_W-1:0] centre);
		int offset;
		case ($urandom_range(0, 5))
			0, 1: return knps_pkg::COORD_W'($urandom);
			2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			3, 4: begin
				offset = int'($urandom_range(0, 1024)) - 512;
				return knps_pkg::COORD_W'(centre + offset);
			end
			default: begin
				// coarse grid around the centre gives many equal distances
				offset = (int'($urandom_range(0, 4)) - 2) * 256;
				return knps_pkg::COORD_W'(centre + offset);
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// compare every result item with the oldest awaited one
	always @(posedge clk) begin
		knps_pkg::out_item_t got;
		neighbour_result_t   want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_neighbours.size() == 0) begin
				$error("result item with nothing awaited: rank %0d slot %0d",
					got.rank, got.neighbour_slot);
				error_count++;
			end else begin
				want = pending_neighbours.pop_front();
				check_field("rank", 32'(want.rank), 32'(got.rank));
				check_field("neighbour_slot", 32'(want.neighbour_slot),
					32'(got.neighbour_slot));
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("distance", 32'(want.distance), 32'(got.distance));
				check_field("found_count", 32'(want.found_count), 32'(got.found_count));
				check_field("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// query straight after reset: every rank empty
	task automatic test_empty_table();
		issue_item(knps_pkg::OP_QUERY, 6'($urandom), 1'($urandom), 24'($urandom),
			24'($urandom), 24'($urandom));
	endtask

	// opposite corners of the coordinate range give the largest distance
	task automatic test_extreme_points();
		issue_item(knps_pkg::OP_LOAD, 6'd0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
		issue_item(knps_pkg::OP_LOAD, 6'd63, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
		issue_item(knps_pkg::OP_QUERY, 6'd63, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, 24'sd0, 24'sd0, 24'sd0);
	endtask

	// equal distances from the origin: lower slot must rank first
	task automatic test_ties();
		issue_item(knps_pkg::OP_LOAD, 6'd12, 1'b1, 24'sd0, 24'sd0, -UNIT);
		issue_item(knps_pkg::OP_LOAD, 6'd9, 1'b1, 24'sd0, UNIT, 24'sd0);
		issue_item(knps_pkg::OP_LOAD, 6'd5, 1'b1, UNIT, 24'sd0, 24'sd0);
		issue_item(knps_pkg::OP_LOAD, 6'd20, 1'b1, knps_pkg::COORD_W'(2 * UNIT),
			knps_pkg::COORD_W'(2 * UNIT), 24'sd0);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, 24'sd0, 24'sd0, 24'sd0);
	endtask

	// a cleared slot drops out, clearing an unwritten slot is harmless
	task automatic test_clear_slot();
		issue_item(knps_pkg::OP_LOAD, 6'd9, 1'b0, 24'($urandom), 24'($urandom),
			24'($urandom));
		issue_item(knps_pkg::OP_QUERY, 6'd9, 1'b1, 24'sd0, 24'sd0, 24'sd0);
		issue_item(knps_pkg::OP_LOAD, 6'd40, 1'b0, 24'($urandom), 24'($urandom),
			24'($urandom));
		issue_item(knps_pkg::OP_LOAD, 6'd9, 1'b1, -UNIT, 24'sd0, 24'sd0);
		issue_item(knps_pkg::OP_QUERY, 6'd40, 1'b0, 24'sd0, 24'sd0, 24'sd0);
	endtask

	// zero acts as one, above eight acts as eight, spare ranks come back empty
	task automatic test_rank_count();
		set_neighbour_count(4'd0);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, UNIT, UNIT, UNIT);
		set_neighbour_count(4'd15);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, 24'sd0, 24'sd0, 24'sd0);
		set_neighbour_count(4'd9);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, COORD_MIN, 24'sd0, COORD_MAX);
		set_neighbour_count(4'd8);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, -UNIT, -UNIT, 24'sd0);
		set_neighbour_count(4'd1);
		issue_item(knps_pkg::OP_QUERY, 6'd0, 1'b0, COORD_MAX, 24'sd0, 24'sd0);
	endtask

	// mixed loads, clears and queries clustered around a moving centre
	task automatic test_random_traffic(input int unsigned idle_pct, stall_pct,
		input int item_total);
		logic signed [knps_pkg::COORD_W-1:0] centre [3];
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		set_neighbour_count(knps_pkg::CFG_W'($urandom));
		for (int n = 0; n < item_total; n++) begin
			if (n % 40 == 0) begin
				foreach (centre[a])
					centre[a] = knps_pkg::COORD_W'($urandom);
			end
			// hold off until every result is back, then change the rank count
			if (n == item_total / 2)
				set_neighbour_count(knps_pkg::CFG_W'($urandom));
			if ($urandom_range(0, 99) < 45)
				issue_item(knps_pkg::OP_QUERY, knps_pkg::SLOT_W'($urandom), 1'($urandom),
					pick_coord(centre[0]), pick_coord(centre[1]), pick_coord(centre[2]));
			else
				issue_item(knps_pkg::OP_LOAD, knps_pkg::SLOT_W'($urandom),
					($urandom_range(0, 99) < 85),
					pick_coord(centre[0]), pick_coord(centre[1]), pick_coord(centre[2]));
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		s_tvalid           = 1'b0;
		s_tuser            = 1'b0;
		s_tdata            = '0;
		m_tready           = 1'b0;
		cfg_wen            = 1'b0;
		cfg_wdata          = '0;
		neighbour_setting  = knps_pkg::CFG_W'(knps_pkg::CFG_RESET);
		sender_idle_pct    = 24;
		receiver_stall_pct = 74;
		foreach (table_present[i])
			table_present[i] = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_extreme_points();
		test_ties();
		test_clear_slot();
		test_rank_count();
		test_random_traffic(24, 74, 130);
		test_random_traffic(74, 24, 130);
		test_random_traffic(0, 0, 140);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
design/knps_pkg.sv
design/knps_ram.sv
design/k_nearest_point_select.sv
design/knps_checker.sv
dv/testbench.sv
